// ===== hw/rtl/dsu_pkg.sv =====
// Shared types and constants for the disjoint-set union engine.
// Depends on nothing; imported by disjoint_set_union_engine.
package dsu_pkg;

  // Item field widths
  localparam int NODE_IN_W   = 10;
  localparam int ROOT_W      = 10;
  localparam int SIZE_W      = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Default store depth
  localparam int DEF_NODES = 1024;

  // Item kinds carried on in_tuser
  localparam logic KIND_UNION = 1'b0;
  localparam logic KIND_FIND  = 1'b1;

  typedef logic [SIZE_W-1:0] size_t;

endpackage

// ===== hw/rtl/disjoint_set_union_engine.sv =====
// Union-find store with union by size and full path compression.
// Each root walk takes hops <= log2(NODES) steps up the parent links.
// Throughput: one item at a time, next accepted the cycle after the result is registered;
// a held result stalls the sequencer in its last state. Reset: synchronous active-low;
// then a clearing pass over every node fills both memories while in_tready stays low.
module disjoint_set_union_engine #(
  parameter int NODES = dsu_pkg::DEF_NODES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dsu_pkg::IN_TDATA_W-1:0]  in_tdata,   // node_a[9:0], node_b[19:10], zero pad
  input  logic                            in_tuser,   // kind
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dsu_pkg::OUT_TDATA_W-1:0] out_tdata,  // root[9:0], set_size[20:10], zero pad
  output logic                            out_tuser   // merged
);

  import dsu_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_FIND_RD  = 4'd2;
  localparam logic [3:0] S_FIND_CHK = 4'd3;
  localparam logic [3:0] S_COMP     = 4'd4;
  localparam logic [3:0] S_WALK_END = 4'd5;
  localparam logic [3:0] S_SZ_A     = 4'd6;
  localparam logic [3:0] S_SZ_B     = 4'd7;
  localparam logic [3:0] S_MERGE    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  // memories
  logic [NW-1:0] parent_mem [NODES];
  size_t         size_mem   [NODES];

  logic [NW-1:0] par_q;
  size_t         sz_q;
  logic [NW-1:0] par_raddr, par_waddr, par_wdata;
  logic          par_we;
  logic [NW-1:0] sz_raddr, sz_waddr;
  size_t         sz_wdata;
  logic          sz_we;

  // control registers
  logic [3:0]    state_r, state_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic          phase_r, phase_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working registers
  logic          kind_r, kind_nxt;
  logic          do_merge_r, do_merge_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] start_r, start_nxt;
  logic [NW-1:0] root_r, root_nxt;
  logic [NW-1:0] ra_r, ra_nxt;
  logic [NW-1:0] rb_r, rb_nxt;
  size_t         sza_r, sza_nxt;
  logic          res_merged_r, res_merged_nxt;
  logic [NW-1:0] res_root_r, res_root_nxt;
  size_t         res_size_r, res_size_nxt;
  logic          out_merged_r;
  logic [NW-1:0] out_root_r;
  size_t         out_size_r;

  logic          in_acc, out_load, a_small;
  logic [NW-1:0] a_cl, b_cl, win_id, lose_id;
  logic [NODE_IN_W-1:0] node_a_in, node_b_in;
  size_t         sum_sz;

  // input fields, clamped to the last node
  assign node_a_in = in_tdata[NODE_IN_W-1:0];
  assign node_b_in = in_tdata[2*NODE_IN_W-1:NODE_IN_W];
  assign a_cl = (32'(node_a_in) >= NODES) ? LAST_NODE : NW'(node_a_in);
  assign b_cl = (32'(node_b_in) >= NODES) ? LAST_NODE : NW'(node_b_in);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // union decision: smaller set goes under larger, ties keep node_a's root
  assign a_small = (sza_r < sz_q);
  assign win_id  = a_small ? rb_r : ra_r;
  assign lose_id = a_small ? ra_r : rb_r;
  assign sum_sz  = sza_r + sz_q;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    do_merge_nxt   = do_merge_r;
    b_nxt          = b_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    root_nxt       = root_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    sza_nxt        = sza_r;
    res_merged_nxt = res_merged_r;
    res_root_nxt   = res_root_r;
    res_size_nxt   = res_size_r;
    par_raddr      = cur_r;
    par_we         = 1'b0;
    par_waddr      = cur_r;
    par_wdata      = root_r;
    sz_raddr       = ra_r;
    sz_we          = 1'b0;
    sz_waddr       = clr_r;
    sz_wdata       = size_t'(1);
    out_load       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_r;
        par_wdata = clr_r;
        sz_we     = 1'b1;
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_tuser;
          b_nxt     = b_cl;
          cur_nxt   = a_cl;
          start_nxt = a_cl;
          phase_nxt = 1'b0;
          state_nxt = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        par_raddr = cur_r;
        state_nxt = S_FIND_CHK;
      end
      // walk up one parent per cycle
      S_FIND_CHK: begin
        if (par_q == cur_r) begin
          root_nxt = cur_r;
          if (start_r == cur_r) begin
            state_nxt = S_WALK_END;
          end else begin
            par_raddr = start_r;
            cur_nxt   = start_r;
            state_nxt = S_COMP;
          end
        end else begin
          par_raddr = par_q;
          cur_nxt   = par_q;
        end
      end
      // second walk: point every visited node at the root
      S_COMP: begin
        par_we    = 1'b1;
        par_waddr = cur_r;
        par_wdata = root_r;
        if (par_q == root_r) begin
          state_nxt = S_WALK_END;
        end else begin
          par_raddr = par_q;
          cur_nxt   = par_q;
        end
      end
      S_WALK_END: begin
        if (kind_r == KIND_FIND) begin
          ra_nxt       = root_r;
          do_merge_nxt = 1'b0;
          state_nxt    = S_SZ_A;
        end else if (!phase_r) begin
          ra_nxt    = root_r;
          cur_nxt   = b_r;
          start_nxt = b_r;
          phase_nxt = 1'b1;
          state_nxt = S_FIND_RD;
        end else begin
          rb_nxt       = root_r;
          do_merge_nxt = (ra_r != root_r);
          state_nxt    = S_SZ_A;
        end
      end
      S_SZ_A: begin
        sz_raddr  = ra_r;
        state_nxt = S_SZ_B;
      end
      S_SZ_B: begin
        sza_nxt = sz_q;
        if (do_merge_r) begin
          sz_raddr  = rb_r;
          state_nxt = S_MERGE;
        end else begin
          res_merged_nxt = 1'b0;
          res_root_nxt   = ra_r;
          res_size_nxt   = sz_q;
          state_nxt      = S_DONE;
        end
      end
      S_MERGE: begin
        par_we         = 1'b1;
        par_waddr      = lose_id;
        par_wdata      = win_id;
        sz_we          = 1'b1;
        sz_waddr       = win_id;
        sz_wdata       = sum_sz;
        res_merged_nxt = 1'b1;
        res_root_nxt   = win_id;
        res_size_nxt   = sum_sz;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    do_merge_r   <= do_merge_nxt;
    b_r          <= b_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    root_r       <= root_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    sza_r        <= sza_nxt;
    res_merged_r <= res_merged_nxt;
    res_root_r   <= res_root_nxt;
    res_size_r   <= res_size_nxt;
    if (out_load) begin
      out_merged_r <= res_merged_r;
      out_root_r   <= res_root_r;
      out_size_r   <= res_size_r;
    end
  end

  // parent and size memories, registered reads
  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_q <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_waddr] <= sz_wdata;
    end
    sz_q <= size_mem[sz_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_merged_r;
  assign out_tdata  = {(OUT_TDATA_W - SIZE_W - ROOT_W)'(0), out_size_r, ROOT_W'(out_root_r)};

  // checks
  a_acc_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_FIND_RD))
    else $error("accepted item did not start a root walk");

  a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (cur_r != root_r))
    else $error("compression rewrote the root itself");

  a_find_no_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && kind_r == KIND_FIND) |-> !res_merged_r)
    else $error("find item reported a merge");

  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_merged_r) |=> (out_merged_r && out_size_r >= size_t'(2)))
    else $error("merged set reported below two nodes");

endmodule
